// ----- sv/min_vertical_travel_time_macros.svh -----
`ifndef MIN_VERTICAL_TRAVEL_TIME_MACROS_SVH
`define MIN_VERTICAL_TRAVEL_TIME_MACROS_SVH

// Clocked check, off while reset is asserted.
`define MVTT_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define MVTT_IMPLIES(lbl, ante, cons, msg) \
    `MVTT_CHECK(lbl, (ante) |-> (cons), msg)

`endif

// ----- sv/mvtt_pkg.sv -----
`default_nettype none
package mvtt_pkg;

    localparam int DIST_W     = 24;
    localparam int VEL_W      = 24;
    localparam int SPD_W      = 23;
    localparam int ACC_W      = 23;
    localparam int TIME_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int SQ_W       = 46;
    localparam int SQ_SHIFT   = 14;
    localparam int RAD_W      = SQ_W + SQ_SHIFT;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int ROOT_SHIFT = 7;
    localparam int NUM_W      = 50;
    localparam int DEN_W      = 47;

    localparam logic [ACC_W-1:0] ACCEL_RESET = 23'd229376;

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_CONST,
        MODE_SHORT,
        MODE_LONG
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        logic [SPD_W-1:0]  u;
        logic [SPD_W-1:0]  w;
        logic [NUM_W-1:0]  num_alt;
        logic [DEN_W-1:0]  den;
    } sq_side_t;

    typedef struct packed {
        logic zero;
        logic sat;
    } div_side_t;

endpackage
`default_nettype wire

// ----- sv/mvtt_isqrt.sv -----
`default_nettype none
module mvtt_isqrt #(
    parameter int RAD_W  = 60,
    parameter int SIDE_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [RAD_W-1:0]    radicand,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [RAD_W/2-1:0]  root,
    output logic [SIDE_W-1:0]   out_side
);
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic              valid_reg [0:ROOT_W-1];
    logic [RAD_W-1:0]  rad_reg   [0:ROOT_W-1];
    logic [REM_W-1:0]  rem_reg   [0:ROOT_W-1];
    logic [ROOT_W-1:0] root_reg  [0:ROOT_W-1];
    logic [SIDE_W-1:0] side_reg  [0:ROOT_W-1];

    // One root bit per stage: bring down two radicand bits, try (root*4+1).
    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              v_in;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SIDE_W-1:0] side_in;
        logic [REM_W+1:0]  rem_sh;
        logic [REM_W+1:0]  trial;
        logic              ge;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;
        logic [RAD_W-1:0]  rad_next;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign rad_in  = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = in_side;
        end
        else begin : g_rest
            assign v_in    = valid_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign rem_sh    = {rem_in, rad_in[RAD_W-1 -: 2]};
        assign trial     = (REM_W+2)'({root_in, 2'b01});
        assign ge        = (rem_sh >= trial);
        assign rem_next  = ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        assign root_next = {root_in[ROOT_W-2:0], ge};
        assign rad_next  = {rad_in[RAD_W-3:0], 2'b00};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]  <= rad_next;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule
`default_nettype wire

// ----- sv/mvtt_div.sv -----
`default_nettype none
module mvtt_div #(
    parameter int NUM_W  = 50,
    parameter int DEN_W  = 47,
    parameter int Q_W    = 32,
    parameter int FRAC_W = 16,
    parameter int SIDE_W = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [NUM_W-1:0]   num,
    input  logic [DEN_W-1:0]   den,
    input  logic [SIDE_W-1:0]  in_side,
    output logic               out_valid,
    output logic [Q_W-1:0]     quot,
    output logic [SIDE_W-1:0]  out_side
);
    localparam int X_W   = NUM_W + FRAC_W;
    localparam int REM_W = DEN_W + 1;

    logic              valid_reg [0:Q_W-1];
    logic [REM_W-1:0]  rem_reg   [0:Q_W-1];
    logic [Q_W-1:0]    xlo_reg   [0:Q_W-1];
    logic [Q_W-1:0]    q_reg     [0:Q_W-1];
    logic [DEN_W-1:0]  den_reg   [0:Q_W-1];
    logic [SIDE_W-1:0] side_reg  [0:Q_W-1];
    logic [X_W-1:0]    x;

    assign x = {num, FRAC_W'(0)};

    // Restoring division, one quotient bit per stage.
    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic              v_in;
        logic [REM_W-1:0]  rem_in;
        logic [Q_W-1:0]    xlo_in;
        logic [Q_W-1:0]    q_in;
        logic [DEN_W-1:0]  den_in;
        logic [SIDE_W-1:0] side_in;
        logic [REM_W:0]    rem_sh;
        logic              ge;
        logic [REM_W-1:0]  rem_next;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = REM_W'(x[X_W-1:Q_W]);
            assign xlo_in  = x[Q_W-1:0];
            assign q_in    = '0;
            assign den_in  = den;
            assign side_in = in_side;
        end
        else begin : g_rest
            assign v_in    = valid_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign xlo_in  = xlo_reg[k-1];
            assign q_in    = q_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign rem_sh   = {rem_in, xlo_in[Q_W-1]};
        assign ge       = (rem_sh >= (REM_W+1)'(den_in));
        assign rem_next = ge ? REM_W'(rem_sh - (REM_W+1)'(den_in)) : REM_W'(rem_sh);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                xlo_reg[k]  <= {xlo_in[Q_W-2:0], 1'b0};
                q_reg[k]    <= {q_in[Q_W-2:0], ge};
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign quot      = q_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule
`default_nettype wire

// ----- sv/min_vertical_travel_time.sv -----
`default_nettype none
// Channel | Direction | Handshake           | Payload
// in      | in        | in_valid/in_stall   | distance, velocity_toward, speed_limit
// out     | out       | out_valid/out_stall | travel_time, time_saturated
// cfg     | in        | cfg_valid/cfg_ready | accel_limit
//
// One beat enters per cycle while nothing stalls; a result passes through four
// setup stages, 30 square-root stages, two selection stages and 32 divider
// stages, one bit per stage.
// Reset clears all valid bits and loads accel_limit with 3.5 m/s^2.
// A stalled result freezes the whole pipeline and raises in_stall.
// cfg_ready is always high.
module min_vertical_travel_time (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [23:0]         distance,
    input  logic signed [23:0]  velocity_toward,
    input  logic [22:0]         speed_limit,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [31:0]         travel_time,
    output logic                time_saturated,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [22:0]         accel_limit
);
    import mvtt_pkg::*;
`include "min_vertical_travel_time_macros.svh"

    logic en;
    logic [ACC_W-1:0] accel_reg;

    // Stage 1: captured beat.
    logic              v1_reg;
    logic [DIST_W-1:0] d1_reg;
    logic [VEL_W-1:0]  vt1_reg;
    logic [SPD_W-1:0]  s1_reg;
    logic [ACC_W-1:0]  a1_reg;

    // Stage 2: clamped speed split into away (u) and toward (w) parts.
    logic              neg_next;
    logic [VEL_W-1:0]  mag_raw_next;
    logic [SPD_W-1:0]  mag_next;
    logic [SPD_W-1:0]  u_next, w_next;
    logic [SPD_W:0]    k_next;
    logic              v2_reg;
    logic [DIST_W-1:0] d2_reg;
    logic [SPD_W-1:0]  s2_reg, u2_reg, w2_reg;
    logic [ACC_W-1:0]  a2_reg;
    logic [SPD_W:0]    k2_reg;
    logic              zero2_reg, const2_reg;

    // Stage 3: products.
    logic              v3_reg;
    logic [46:0]       ad3_reg;
    logic [45:0]       uu3_reg, ww3_reg, ss3_reg, as3_reg;
    logic [47:0]       kk3_reg;
    logic [DIST_W-1:0] d3_reg;
    logic [SPD_W-1:0]  s3_reg, u3_reg, w3_reg;
    logic [ACC_W-1:0]  a3_reg;
    logic              zero3_reg, const3_reg;

    // Stage 4: path choice and radicand.
    logic [47:0]       two_ad_next;
    logic [48:0]       lhs_next;
    logic [45:0]       rhs_next;
    logic [48:0]       q_next;
    logic [NUM_W-1:0]  n_long_next;
    sq_side_t          side4_next;
    logic [RAD_W-1:0]  rad_next;
    logic              v4_reg;
    sq_side_t          side4_reg;
    logic [RAD_W-1:0]  rad4_reg;

    // Square-root pipeline.
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    logic [$bits(sq_side_t)-1:0] sq_side_vec;
    sq_side_t          sq_side;

    // Stage 5: numerator pick.
    logic [ROOT_W:0]   m_next;
    logic              v5_reg;
    mode_t             mode5_reg;
    logic [NUM_W-1:0]  num5_reg;
    logic [DEN_W-1:0]  den5_reg;

    // Stage 6: saturation test.
    logic              v6_reg;
    logic [NUM_W-1:0]  num6_reg;
    logic [DEN_W-1:0]  den6_reg;
    div_side_t         side6_reg;

    logic              dv_valid;
    logic [TIME_W-1:0] dv_quot;
    logic [$bits(div_side_t)-1:0] dv_side_vec;
    div_side_t         dv_side;

    // Advance everything unless a finished result is held back.
    assign en        = !(out_valid && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg <= ACCEL_RESET;
        end
        else if (cfg_valid)
        begin
            accel_reg <= accel_limit;
        end
    end

    // Valid chain for the setup and selection stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= sq_valid;
            v6_reg <= v5_reg;
        end
    end

    // Clamp the speed magnitude to the limit; the most negative code
    // negates to itself, which is the right magnitude.
    assign neg_next     = vt1_reg[VEL_W-1];
    assign mag_raw_next = neg_next ? VEL_W'(-vt1_reg) : vt1_reg;
    assign mag_next     = (mag_raw_next > VEL_W'(s1_reg)) ? s1_reg
                                                          : SPD_W'(mag_raw_next);
    assign u_next       = neg_next ? mag_next : '0;
    assign w_next       = neg_next ? '0 : mag_next;
    assign k_next       = (SPD_W+1)'(s1_reg) + (SPD_W+1)'(u_next)
                          - (SPD_W+1)'(w_next);

    // Long move: 2AD plus the squared velocity deficit, over 2AS.
    // Short move: the peak speed is sqrt(W^2 + U^2 + 2AD).
    assign two_ad_next = {ad3_reg, 1'b0};
    assign lhs_next    = 49'(two_ad_next) + 49'(uu3_reg);
    assign rhs_next    = ss3_reg - ww3_reg;
    assign q_next      = lhs_next + 49'(ww3_reg);
    assign n_long_next = NUM_W'(two_ad_next) + NUM_W'(kk3_reg);
    assign rad_next    = {q_next[SQ_W-1:0], SQ_SHIFT'(0)};

    always_comb
    begin
        side4_next.u       = u3_reg;
        side4_next.w       = w3_reg;
        side4_next.mode    = MODE_LONG;
        side4_next.num_alt = n_long_next;
        side4_next.den     = {as3_reg, 1'b0};
        if (zero3_reg)
        begin
            side4_next.mode    = MODE_ZERO;
            side4_next.num_alt = '0;
            side4_next.den     = DEN_W'(1);
        end
        else if (const3_reg)
        begin
            side4_next.mode    = MODE_CONST;
            side4_next.num_alt = NUM_W'(d3_reg);
            side4_next.den     = DEN_W'(s3_reg);
        end
        else if (lhs_next <= 49'(rhs_next))
        begin
            side4_next.mode = MODE_SHORT;
            side4_next.den  = DEN_W'({a3_reg, ROOT_SHIFT'(0)});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg     <= distance;
            vt1_reg    <= velocity_toward;
            s1_reg     <= speed_limit;
            a1_reg     <= accel_reg;

            d2_reg     <= d1_reg;
            s2_reg     <= s1_reg;
            a2_reg     <= a1_reg;
            u2_reg     <= u_next;
            w2_reg     <= w_next;
            k2_reg     <= k_next;
            zero2_reg  <= (d1_reg == '0) || (s1_reg == '0);
            const2_reg <= (a1_reg == '0);

            ad3_reg    <= 47'(a2_reg) * 47'(d2_reg);
            uu3_reg    <= 46'(u2_reg) * 46'(u2_reg);
            ww3_reg    <= 46'(w2_reg) * 46'(w2_reg);
            ss3_reg    <= 46'(s2_reg) * 46'(s2_reg);
            as3_reg    <= 46'(a2_reg) * 46'(s2_reg);
            kk3_reg    <= 48'(k2_reg) * 48'(k2_reg);
            d3_reg     <= d2_reg;
            s3_reg     <= s2_reg;
            u3_reg     <= u2_reg;
            w3_reg     <= w2_reg;
            a3_reg     <= a2_reg;
            zero3_reg  <= zero2_reg;
            const3_reg <= const2_reg;

            side4_reg  <= side4_next;
            rad4_reg   <= rad_next;
        end
    end

    mvtt_isqrt #(
        .RAD_W  (RAD_W),
        .SIDE_W ($bits(sq_side_t))
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v4_reg),
        .radicand  (rad4_reg),
        .in_side   (side4_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side_vec)
    );

    assign sq_side = sq_side_t'(sq_side_vec);

    // Short move numerator: U*2^7 + root - W*2^7, never negative.
    assign m_next = (ROOT_W+1)'({sq_side.u, ROOT_SHIFT'(0)}) + (ROOT_W+1)'(sq_root)
                    - (ROOT_W+1)'({sq_side.w, ROOT_SHIFT'(0)});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode5_reg <= sq_side.mode;
            num5_reg  <= (sq_side.mode == MODE_SHORT) ? NUM_W'(m_next) : sq_side.num_alt;
            den5_reg  <= sq_side.den;

            // Quotient reaches 2^32 exactly when num >= den * 2^16.
            num6_reg       <= num5_reg;
            den6_reg       <= den5_reg;
            side6_reg.zero <= (mode5_reg == MODE_ZERO);
            side6_reg.sat  <= ((NUM_W+FRAC_W)'(num5_reg) >= {den5_reg, FRAC_W'(0)})
                              && (mode5_reg != MODE_ZERO);
        end
    end

    mvtt_div #(
        .NUM_W  (NUM_W + 0),
        .DEN_W  (DEN_W),
        .Q_W    (TIME_W),
        .FRAC_W (FRAC_W),
        .SIDE_W ($bits(div_side_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v6_reg),
        .num       (num6_reg),
        .den       (den6_reg),
        .in_side   (side6_reg),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .out_side  (dv_side_vec)
    );

    assign dv_side        = div_side_t'(dv_side_vec);
    assign out_valid      = dv_valid;
    assign time_saturated = dv_side.sat;
    assign travel_time    = dv_side.zero ? '0 : (dv_side.sat ? '1 : dv_quot);

    `MVTT_IMPLIES(a_sat_max, out_valid && time_saturated, travel_time == '1, "saturated time not all ones")
    `MVTT_IMPLIES(a_root_floor, sq_valid && sq_side.mode == MODE_SHORT, sq_root >= ROOT_W'({sq_side.w, ROOT_SHIFT'(0)}), "root below start speed")
    `MVTT_IMPLIES(a_dir_split, v2_reg, u2_reg == '0 || w2_reg == '0, "speed counted in both directions")

endmodule
`default_nettype wire
